// ===== hdl/rsi_pkg.sv =====
// rsi_pkg: widths, codes and the square-root step shared by the ray-sphere test.
// No dependencies; used by rsi_sqrt and ray_sphere_intersection.
`timescale 1ns / 1ps

package rsi_pkg;

  localparam int FRAC_BITS_DEF = 16;   // default fraction bits of positions
  localparam int DIR_BITS      = 16;   // fraction bits of the direction
  localparam int POS_W         = 32;
  localparam int DIR_W         = 18;
  localparam int V_W           = 33;   // center - origin
  localparam int PROD_W        = 51;   // dir * v
  localparam int DOT_W         = 53;   // sum of three products
  localparam int D1_W          = 37;   // projection after the floor shift
  localparam int SQ_W          = 66;   // one square of v
  localparam int VV_W          = 66;   // |v|^2
  localparam int LO_W          = 32;   // low slice of |d1|
  localparam int HI_W          = 5;    // high slice of |d1|
  localparam int LHS_W         = 76;   // d1^2 + r^2, also the radicand
  localparam int SQRT_STEPS    = 38;
  localparam int ROOT_W        = 38;
  localparam int REM_W         = 40;
  localparam int STEPS_PER_STG = 2;
  localparam int SQRT_STG      = SQRT_STEPS / STEPS_PER_STG;
  localparam int T_W           = 40;   // signed near/far roots
  localparam int SIDE_W        = 1 + D1_W + POS_W;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    HIT_MISS    = 2'd0,
    HIT_OUTSIDE = 2'd1,
    HIT_INSIDE  = 2'd2
  } hit_kind_t;

  typedef enum logic [1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_CENTER_Z  = 2'd2,
    REG_RADIUS_SQ = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sq_st_t;

  typedef struct packed {
    logic                   ok;
    logic signed [D1_W-1:0] d1;
    logic [POS_W-1:0]       best;
  } side_t;

  // one digit of the restoring integer square root
  function automatic sq_st_t sqrt_step(input sq_st_t s, input logic [1:0] pair);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] t;
    sq_st_t           o;
    r = {s.rem[REM_W-3:0], pair};
    t = {s.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== hdl/rsi_sqrt.sv =====
// rsi_sqrt: pipelined floored integer square root, two digits per stage.
// Depends on rsi_pkg; carries a sideband word alongside each root.
`timescale 1ns / 1ps

module rsi_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [rsi_pkg::LHS_W-1:0]  in_rad,
  input  rsi_pkg::side_t             in_side,
  output logic                       out_v,
  output logic [rsi_pkg::ROOT_W-1:0] out_root,
  output rsi_pkg::side_t             out_side
);

  logic                      v_r    [rsi_pkg::SQRT_STG];
  rsi_pkg::sq_st_t           st_r   [rsi_pkg::SQRT_STG];
  logic [rsi_pkg::LHS_W-1:0] rad_r  [rsi_pkg::SQRT_STG];
  rsi_pkg::side_t            side_r [rsi_pkg::SQRT_STG];

  for (genvar g = 0; g < rsi_pkg::SQRT_STG; g++) begin : g_stg
    logic                      prev_v;
    rsi_pkg::sq_st_t           prev_st;
    logic [rsi_pkg::LHS_W-1:0] prev_rad;
    rsi_pkg::side_t            prev_side;
    rsi_pkg::sq_st_t           st_nxt;
    logic [rsi_pkg::LHS_W-1:0] rad_nxt;

    if (g == 0) begin : g_first
      assign prev_v    = in_v;
      assign prev_st   = '0;
      assign prev_rad  = in_rad;
      assign prev_side = in_side;
    end else begin : g_rest
      assign prev_v    = v_r[g-1];
      assign prev_st   = st_r[g-1];
      assign prev_rad  = rad_r[g-1];
      assign prev_side = side_r[g-1];
    end

    always_comb begin : step_c
      rsi_pkg::sq_st_t           s;
      logic [rsi_pkg::LHS_W-1:0] rd;
      s  = prev_st;
      rd = prev_rad;
      for (int k = 0; k < rsi_pkg::STEPS_PER_STG; k++) begin
        s  = rsi_pkg::sqrt_step(s, rd[rsi_pkg::LHS_W-1 -: 2]);
        rd = {rd[rsi_pkg::LHS_W-3:0], 2'b00};
      end
      st_nxt  = s;
      rad_nxt = rd;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g]   <= st_nxt;
        rad_r[g]  <= rad_nxt;
        side_r[g] <= prev_side;
      end
    end
  end

  assign out_v    = v_r[rsi_pkg::SQRT_STG-1];
  assign out_root = st_r[rsi_pkg::SQRT_STG-1].root;
  assign out_side = side_r[rsi_pkg::SQRT_STG-1];

endmodule

// ===== hdl/ray_sphere_intersection.sv =====
// Ray-sphere intersection, one ray per clock unless a held output stalls the pipe.
// Stages: 1 v = c - o, 2 products and squares, 3 dot and |v|^2, 4 d1^2 partials,
// 5 lhs/compare into the root pipe (19 stages, two digits each), 1 classify and output.
// A held output (out_valid high, out_ready low) freezes every stage; nothing drops.
// Reset (synchronous, rst_n low) clears all valid bits and loads the config defaults.
// Depends on rsi_pkg and rsi_sqrt.
`timescale 1ns / 1ps

module ray_sphere_intersection #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // APB-style config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsi_pkg::ADDR_W-1:0]        paddr,
  input  logic [rsi_pkg::DATA_W-1:0]        pwdata,
  output logic [rsi_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  // ray input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_origin_x,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_origin_y,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_z,
  input  logic [rsi_pkg::POS_W-1:0]         in_best_dist,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_hit_kind,
  output logic [rsi_pkg::POS_W-1:0]         out_new_dist
);

  localparam int LHS_W = rsi_pkg::LHS_W;
  localparam int T_W   = rsi_pkg::T_W;

  // ---------------- configuration registers ----------------
  logic signed [rsi_pkg::POS_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [rsi_pkg::POS_W-1:0]        radius_sq_r;
  rsi_pkg::cfg_reg_t                reg_sel;
  logic                             cfg_wr;

  assign reg_sel = rsi_pkg::cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      center_z_r  <= '0;
      radius_sq_r <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        rsi_pkg::REG_CENTER_X:  center_x_r  <= pwdata;
        rsi_pkg::REG_CENTER_Y:  center_y_r  <= pwdata;
        rsi_pkg::REG_CENTER_Z:  center_z_r  <= pwdata;
        rsi_pkg::REG_RADIUS_SQ: radius_sq_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rsi_pkg::REG_CENTER_X:  prdata = center_x_r;
      rsi_pkg::REG_CENTER_Y:  prdata = center_y_r;
      rsi_pkg::REG_CENTER_Z:  prdata = center_z_r;
      rsi_pkg::REG_RADIUS_SQ: prdata = radius_sq_r;
      default:                prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // Global advance: every stage moves when the output slot is free or drained.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: v = center - origin ----------------
  logic                             s1_v_r;
  logic signed [rsi_pkg::V_W-1:0]   s1_vx_r, s1_vy_r, s1_vz_r;
  logic signed [rsi_pkg::DIR_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic [rsi_pkg::POS_W-1:0]        s1_best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vx_r   <= rsi_pkg::V_W'(center_x_r) - rsi_pkg::V_W'(in_origin_x);
      s1_vy_r   <= rsi_pkg::V_W'(center_y_r) - rsi_pkg::V_W'(in_origin_y);
      s1_vz_r   <= rsi_pkg::V_W'(center_z_r) - rsi_pkg::V_W'(in_origin_z);
      s1_dx_r   <= in_dir_x;
      s1_dy_r   <= in_dir_y;
      s1_dz_r   <= in_dir_z;
      s1_best_r <= in_best_dist;
    end
  end

  // ---------------- stage 2: dir*v products and squares of v ----------------
  logic                              s2_v_r;
  logic signed [rsi_pkg::PROD_W-1:0] s2_px_r, s2_py_r, s2_pz_r;
  logic signed [rsi_pkg::SQ_W-1:0]   s2_qx_r, s2_qy_r, s2_qz_r;
  logic [rsi_pkg::POS_W-1:0]         s2_best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_px_r   <= rsi_pkg::PROD_W'(s1_dx_r) * rsi_pkg::PROD_W'(s1_vx_r);
      s2_py_r   <= rsi_pkg::PROD_W'(s1_dy_r) * rsi_pkg::PROD_W'(s1_vy_r);
      s2_pz_r   <= rsi_pkg::PROD_W'(s1_dz_r) * rsi_pkg::PROD_W'(s1_vz_r);
      s2_qx_r   <= rsi_pkg::SQ_W'(s1_vx_r) * rsi_pkg::SQ_W'(s1_vx_r);
      s2_qy_r   <= rsi_pkg::SQ_W'(s1_vy_r) * rsi_pkg::SQ_W'(s1_vy_r);
      s2_qz_r   <= rsi_pkg::SQ_W'(s1_vz_r) * rsi_pkg::SQ_W'(s1_vz_r);
      s2_best_r <= s1_best_r;
    end
  end

  // ---------------- stage 3: projection d1 and |v|^2 ----------------
  logic                              s3_v_r;
  logic signed [rsi_pkg::D1_W-1:0]   s3_d1_r;
  logic [rsi_pkg::VV_W-1:0]          s3_vv_r;
  logic [rsi_pkg::POS_W-1:0]         s3_best_r;
  logic signed [rsi_pkg::DOT_W-1:0]  dot;

  assign dot = rsi_pkg::DOT_W'(s2_px_r) + rsi_pkg::DOT_W'(s2_py_r) + rsi_pkg::DOT_W'(s2_pz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // arithmetic shift is the floor division
      s3_d1_r   <= dot[rsi_pkg::DOT_W-1:rsi_pkg::DIR_BITS];
      s3_vv_r   <= unsigned'(s2_qx_r) + unsigned'(s2_qy_r) + unsigned'(s2_qz_r);
      s3_best_r <= s2_best_r;
    end
  end

  // ---------------- stage 4: d1^2 as three partial products ----------------
  logic                             s4_v_r;
  logic signed [rsi_pkg::D1_W-1:0]  s4_d1_r;
  logic [rsi_pkg::VV_W-1:0]         s4_vv_r;
  logic [rsi_pkg::POS_W-1:0]        s4_best_r;
  logic [2*rsi_pkg::LO_W-1:0]       s4_ll_r;
  logic [rsi_pkg::LO_W+rsi_pkg::HI_W-1:0] s4_hl_r;
  logic [2*rsi_pkg::HI_W-1:0]       s4_hh_r;
  logic [rsi_pkg::D1_W-1:0]         d1_mag;

  assign d1_mag = s3_d1_r[rsi_pkg::D1_W-1] ? rsi_pkg::D1_W'(-s3_d1_r) : unsigned'(s3_d1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ll_r   <= (2*rsi_pkg::LO_W)'(d1_mag[rsi_pkg::LO_W-1:0])
                   * (2*rsi_pkg::LO_W)'(d1_mag[rsi_pkg::LO_W-1:0]);
      s4_hl_r   <= (rsi_pkg::LO_W+rsi_pkg::HI_W)'(d1_mag[rsi_pkg::D1_W-1:rsi_pkg::LO_W])
                   * (rsi_pkg::LO_W+rsi_pkg::HI_W)'(d1_mag[rsi_pkg::LO_W-1:0]);
      s4_hh_r   <= (2*rsi_pkg::HI_W)'(d1_mag[rsi_pkg::D1_W-1:rsi_pkg::LO_W])
                   * (2*rsi_pkg::HI_W)'(d1_mag[rsi_pkg::D1_W-1:rsi_pkg::LO_W]);
      s4_d1_r   <= s3_d1_r;
      s4_vv_r   <= s3_vv_r;
      s4_best_r <= s3_best_r;
    end
  end

  // ---------------- stage 5: lhs = d1^2 + r^2, overlap test, radicand ----------------
  logic [LHS_W-1:0] d1_sq, r2, lhs, vv_x, rad;
  rsi_pkg::side_t   side_in;
  logic             s5_v_r;
  logic [LHS_W-1:0] s5_rad_r;
  rsi_pkg::side_t   s5_side_r;

  assign d1_sq = (LHS_W'(s4_hh_r) << (2*rsi_pkg::LO_W))
               + (LHS_W'(s4_hl_r) << (rsi_pkg::LO_W + 1))
               + LHS_W'(s4_ll_r);
  assign r2    = LHS_W'(radius_sq_r) << FRAC_BITS;
  assign lhs   = d1_sq + r2;
  assign vv_x  = LHS_W'(s4_vv_r);
  assign rad   = lhs - vv_x;

  assign side_in.ok   = (vv_x <= lhs);
  assign side_in.d1   = s4_d1_r;
  assign side_in.best = s4_best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_rad_r  <= rad;
      s5_side_r <= side_in;
    end
  end

  // ---------------- square root pipe ----------------
  logic                       sq_v;
  logic [rsi_pkg::ROOT_W-1:0] sq_root;
  rsi_pkg::side_t             sq_side;

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (s5_v_r),
    .in_rad   (s5_rad_r),
    .in_side  (s5_side_r),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------- classify: near/far roots against best ----------------
  logic signed [T_W-1:0] near_t, far_t, best_t;
  rsi_pkg::hit_kind_t    kind_nxt;
  logic [rsi_pkg::POS_W-1:0] dist_nxt;

  assign near_t = T_W'(sq_side.d1) - signed'(T_W'(sq_root));
  assign far_t  = T_W'(sq_side.d1) + signed'(T_W'(sq_root));
  assign best_t = signed'(T_W'(sq_side.best));

  always_comb begin
    kind_nxt = rsi_pkg::HIT_MISS;
    dist_nxt = sq_side.best;
    if (sq_side.ok && far_t >= 0) begin
      if (near_t > 0) begin
        if (best_t > near_t) begin
          kind_nxt = rsi_pkg::HIT_OUTSIDE;
          dist_nxt = near_t[rsi_pkg::POS_W-1:0];
        end
      end else if (best_t > far_t) begin
        // origin inside or on the surface: exit point counts
        kind_nxt = rsi_pkg::HIT_INSIDE;
        dist_nxt = far_t[rsi_pkg::POS_W-1:0];
      end
    end
  end

  // ---------------- output register ----------------
  logic                      out_valid_r;
  logic [1:0]                out_hit_kind_r;
  logic [rsi_pkg::POS_W-1:0] out_new_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= sq_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_kind_r <= kind_nxt;
      out_new_dist_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit_kind = out_hit_kind_r;
  assign out_new_dist = out_new_dist_r;

`ifndef SYNTHESIS
  // a reported hit is always strictly nearer than the incoming best
  a_hit_nearer: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v && kind_nxt != rsi_pkg::HIT_MISS |-> dist_nxt < sq_side.best)
    else $error("hit not nearer than best");

  // a miss passes best through untouched
  a_miss_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v && kind_nxt == rsi_pkg::HIT_MISS |-> dist_nxt == sq_side.best)
    else $error("miss changed distance");

  // a frozen pipe keeps the root pipe's head in place
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sq_v) && $stable(sq_root))
    else $error("root pipe moved during stall");
`endif

endmodule
